FILE: hw/rtl/crc32mw_pkg.sv
// Types, codes and CRC folding functions shared by the multiwidth CRC-32 unit.
// Depends on nothing; every other file of the block takes names from here.
`timescale 1ns / 1ps
`default_nettype none

package crc32mw_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] FP_ALL_ONES = 32'hFFFFFFFF;
    localparam logic [15:0] STRING_CAP_RESET = 16'd256;
    localparam logic [31:0] INITIAL_CRC_RESET = 32'h0000_0000;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_CRC = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_CAP = 1'd1;

    typedef enum logic [2:0] {
        CMD_BYTE     = 3'd0,
        CMD_WORD32   = 3'd1,
        CMD_WORD64   = 3'd2,
        CMD_STR_CHAR = 3'd3,
        CMD_NULL_STR = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] data;
        logic        restart;
        logic        string_start;
    } in_item_t;

    typedef struct packed {
        logic [31:0] crc_value;
        logic [31:0] fingerprint;
        logic        consumed;
    } out_item_t;

    // Progress through the bounded string currently being hashed.
    typedef struct packed {
        logic [15:0] count;
        logic        stopped;
    } str_state_t;

    // Everything one beat leaves behind: the result and the new state.
    typedef struct packed {
        out_item_t  item;
        logic [31:0] crc;
        str_state_t str;
    } fold_result_t;

    // One byte through the reflected register, least significant bit first.
    function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                              input logic [7:0] byte_in);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, byte_in};
        for (int b = 0; b < 8; b++) begin
            crc = {1'b0, crc[31:1]} ^ (crc[0] ? CRC_POLY : 32'd0);
        end
        return crc;
    endfunction

    function automatic logic [31:0] fold_word32(input logic [31:0] crc_in,
                                                input logic [31:0] word_in);
        logic [31:0] crc;
        crc = crc_in;
        for (int i = 0; i < 4; i++) begin
            crc = fold_byte(crc, word_in[8*i +: 8]);
        end
        return crc;
    endfunction

    function automatic logic [31:0] fold_word64(input logic [31:0] crc_in,
                                                input logic [63:0] word_in);
        logic [31:0] crc;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            crc = fold_byte(crc, word_in[8*i +: 8]);
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/crc32mw_in_if.sv
// Input channel of the CRC-32 unit: valid, ready and one request item.
// Depends on crc32mw_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

interface crc32mw_in_if;

    logic                 valid;
    logic                 ready;
    crc32mw_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/crc32mw_out_if.sv
// Output channel of the CRC-32 unit: valid, ready and one result item.
// Depends on crc32mw_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

interface crc32mw_out_if;

    logic                  valid;
    logic                  ready;
    crc32mw_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/crc32mw_fold.sv
// Combinational fold of one request into the running CRC and string state.
// Depends on crc32mw_pkg for item types, command codes and fold functions.
`timescale 1ns / 1ps
`default_nettype none

module crc32mw_fold (
    input  crc32mw_pkg::in_item_t     item,
    input  logic [31:0]               running_crc,
    input  crc32mw_pkg::str_state_t   str_state,
    input  logic [31:0]               initial_crc,
    input  logic [15:0]               string_cap,
    output crc32mw_pkg::fold_result_t result
);

    logic [31:0]             base_crc;
    logic [31:0]             crc_new;
    logic                    consumed;
    crc32mw_pkg::str_state_t str_cur;
    crc32mw_pkg::str_state_t str_new;

    assign base_crc = item.restart ? initial_crc : running_crc;

    // On a string character, a start mark clears the string state even when the character is then ignored.
    always_comb
    begin
        if (item.string_start)
        begin
            str_cur.count = 16'd0;
            str_cur.stopped = 1'b0;
        end
        else
        begin
            str_cur = str_state;
        end
    end

    always_comb
    begin
        crc_new = base_crc;
        consumed = 1'b1;
        str_new = str_state;
        unique case (item.cmd)
            crc32mw_pkg::CMD_BYTE:
            begin
                crc_new = crc32mw_pkg::fold_byte(base_crc, item.data[7:0]);
            end
            crc32mw_pkg::CMD_WORD32:
            begin
                crc_new = crc32mw_pkg::fold_word32(base_crc, item.data[31:0]);
            end
            crc32mw_pkg::CMD_WORD64:
            begin
                crc_new = crc32mw_pkg::fold_word64(base_crc, item.data);
            end
            crc32mw_pkg::CMD_STR_CHAR:
            begin
                str_new = str_cur;
                if (str_cur.stopped || (str_cur.count >= string_cap))
                begin
                    consumed = 1'b0;
                end
                else
                begin
                    crc_new = crc32mw_pkg::fold_byte(base_crc, item.data[7:0]);
                    str_new.count = 16'(str_cur.count + 16'd1);
                    str_new.stopped = (item.data[7:0] == 8'd0);
                end
            end
            crc32mw_pkg::CMD_NULL_STR:
            begin
                crc_new = crc32mw_pkg::fold_word32(base_crc, 32'd0);
            end
            default:
            begin
                consumed = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.crc = crc_new;
        result.str = str_new;
        result.item.crc_value = crc_new;
        result.item.fingerprint = (crc_new != 32'd0) ? crc_new : crc32mw_pkg::FP_ALL_ONES;
        result.item.consumed = consumed;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crc32_multiwidth_update_unit.sv
// Top level of the multiwidth reflected CRC-32 update unit.
// Depends on crc32mw_pkg, crc32mw_in_if, crc32mw_out_if and crc32mw_fold.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// in_ch     sink       cmd, data, restart, string_start
// out_ch    source     crc_value, fingerprint, consumed
// cfg_*     write      register index 0 initial_crc, 1 string_cap
//
// A beat taken from in_ch is held in the input register, is folded by one XOR
// network into the result register once that register is free, and is offered on
// out_ch from then on; with out_ch taking, one beat moves every cycle.
// Reset clears the handshake flags, the running CRC and the string state, and
// loads the configuration registers with their reset values.
// A stall on out_ch holds the result; in_ch stays ready until the input register also fills.
module crc32_multiwidth_update_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    crc32mw_in_if.sink                            in_ch,
    crc32mw_out_if.source                         out_ch,
    input  logic                                  cfg_we,
    input  logic [crc32mw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [crc32mw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // Configuration registers.
    logic [31:0] initial_crc_reg;
    logic [15:0] string_cap_reg;

    // Running state carried from beat to beat.
    logic [31:0]             running_crc_reg;
    logic [31:0]             running_crc_next;
    crc32mw_pkg::str_state_t str_state_reg;
    crc32mw_pkg::str_state_t str_state_next;

    // Input register and result register.
    logic                     in_valid_reg;
    logic                     in_valid_next;
    crc32mw_pkg::in_item_t    in_item_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    crc32mw_pkg::out_item_t   out_item_reg;

    crc32mw_pkg::fold_result_t fold_result;

    logic out_free;
    logic advance;
    logic in_take;

    // The result register is free when empty or when its beat leaves now.
    assign out_free = !out_valid_reg || out_ch.ready;
    assign advance = in_valid_reg && out_free;
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take = in_ch.valid && in_ch.ready;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.item = out_item_reg;

    // The user must write the registers only while the unit is idle; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_crc_reg <= crc32mw_pkg::INITIAL_CRC_RESET;
            string_cap_reg <= crc32mw_pkg::STRING_CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crc32mw_pkg::CFG_INITIAL_CRC:
                begin
                    initial_crc_reg <= cfg_wdata[31:0];
                end
                crc32mw_pkg::CFG_STRING_CAP:
                begin
                    string_cap_reg <= cfg_wdata[15:0];
                end
                default:
                begin
                    initial_crc_reg <= initial_crc_reg;
                end
            endcase
        end
    end

    crc32mw_fold u_fold (
        .item        (in_item_reg),
        .running_crc (running_crc_reg),
        .str_state   (str_state_reg),
        .initial_crc (initial_crc_reg),
        .string_cap  (string_cap_reg),
        .result      (fold_result)
    );

    // State moves only when the beat in the input register is folded.
    always_comb
    begin
        running_crc_next = running_crc_reg;
        str_state_next = str_state_reg;
        if (advance)
        begin
            running_crc_next = fold_result.crc;
            str_state_next = fold_result.str;
        end
    end

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            running_crc_reg <= 32'd0;
            str_state_reg <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            running_crc_reg <= running_crc_next;
            str_state_reg <= str_state_next;
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_ch.item;
        end
        if (advance)
        begin
            out_item_reg <= fold_result.item;
        end
    end

endmodule

`default_nettype wire
